// ===== rtl/core/dllm_pkg.sv =====
`default_nettype none

package dllm_pkg;

  // Pool and list sizing
  localparam int NODE_COUNT = 256;
  localparam int LIST_COUNT = 16;

  // Field widths of the channels
  localparam int CMD_W  = 3;
  localparam int LIST_W = 4;
  localparam int NODE_W = 9;

  // Derived storage widths (LIST_COUNT is a power of two)
  localparam int ADDR_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LSEL_W = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_REMOVE     = 3'd0,
    CMD_INS_TAIL   = 3'd1,
    CMD_INS_HEAD   = 3'd2,
    CMD_INS_BEFORE = 3'd3,
    CMD_INS_AFTER  = 3'd4,
    CMD_MOVE       = 3'd5,
    CMD_CLEAR      = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_STEP_A,
    ST_STEP_B,
    ST_STEP_C,
    ST_DONE
  } state_t;

  typedef logic [NODE_W-1:0] node_t;

  // Node numbers beyond the pool mean "none"
  function automatic node_t node_of(input node_t v);
    node_t r;
    r = (v > NODE_W'(NODE_COUNT)) ? '0 : v;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dllm_if.sv =====
`default_nettype none

// Command channel
interface dllm_in_if;
  logic                          valid;
  logic                          ready;
  logic [dllm_pkg::CMD_W-1:0]    command;
  logic [dllm_pkg::LIST_W-1:0]   list_id;
  logic [dllm_pkg::LIST_W-1:0]   source_list;
  logic [dllm_pkg::NODE_W-1:0]   item_node;
  logic [dllm_pkg::NODE_W-1:0]   anchor_node;
  logic [dllm_pkg::NODE_W-1:0]   range_end;

  modport source (output valid, command, list_id, source_list, item_node,
                  anchor_node, range_end, input ready);
  modport sink   (input valid, command, list_id, source_list, item_node,
                  anchor_node, range_end, output ready);
endinterface

// Result channel
interface dllm_out_if;
  logic                          valid;
  logic                          ready;
  logic [dllm_pkg::NODE_W-1:0]   successor_node;
  logic [dllm_pkg::NODE_W-1:0]   head_node;
  logic [dllm_pkg::NODE_W-1:0]   tail_node;

  modport source (output valid, successor_node, head_node, tail_node,
                  input ready);
  modport sink   (input valid, successor_node, head_node, tail_node,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/doubly_linked_list_manager_top.sv =====
`default_nettype none

// Doubly linked list manager: keeps 16 lists over a pool of 256 nodes (node 0 = none).
// Node links live in two single-port synchronous RAMs (next and prev); list heads and
// tails live in registers cleared by reset. One command is handled at a time: after
// the accept, ST_READ fetches the needed links, then the write steps STEP_A, STEP_B
// and STEP_C, as far as the command needs them, apply the link updates in order, as
// the single write port of each link RAM demands; then in ST_DONE the result (removed
// node's successor, head and tail of list_id) is loaded into an output register. The
// next command can be accepted in the cycle in which that result becomes valid; a new
// command is accepted while a result still waits, and it holds in ST_DONE until that
// result is taken. Nodes passed in must be consistent with the lists; nothing is checked.
module doubly_linked_list_manager_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  dllm_in_if.sink     in_ch,
  dllm_out_if.source  out_ch
);

  dllm_pkg::state_t state_r, state_nxt;

  // Command registers
  dllm_pkg::cmd_t                cmd_r;
  logic [dllm_pkg::LSEL_W-1:0]   lid_r, src_r;
  dllm_pkg::node_t               item_r, anchor_r, last_r;

  // Link RAMs and their registered read data
  dllm_pkg::node_t next_mem [dllm_pkg::NODE_COUNT];
  dllm_pkg::node_t prev_mem [dllm_pkg::NODE_COUNT];
  dllm_pkg::node_t next_q_r, prev_q_r;
  logic            next_z_r, prev_z_r;

  // List ends
  dllm_pkg::node_t head_r [dllm_pkg::LIST_COUNT];
  dllm_pkg::node_t tail_r [dllm_pkg::LIST_COUNT];

  // Output register
  logic            out_valid_r;
  dllm_pkg::node_t succ_out_r, head_out_r, tail_out_r;

  // Combinational controls
  logic                          accept;
  logic                          rd_en;
  dllm_pkg::node_t               nr_node, pr_node;
  logic [dllm_pkg::LSEL_W-1:0]   lst_addr;
  dllm_pkg::node_t               cur_head, cur_tail, nx, pr;
  logic                          nw_req, pw_req, hw_en, tw_en;
  dllm_pkg::node_t               nw_node, nw_data, pw_node, pw_data, hw_data, tw_data;
  logic                          nw_en, pw_en;
  logic [dllm_pkg::ADDR_W-1:0]   nw_addr, pw_addr;
  logic                          out_load;
  logic                          go;

  assign accept = in_ch.valid && in_ch.ready;

  // Read addresses: remove reads both links of the item, move reads prev of
  // begin and next of end, insert before/after reads the anchor's link
  always_comb begin
    case (cmd_r)
      dllm_pkg::CMD_REMOVE: begin
        nr_node = item_r;
        pr_node = item_r;
      end
      dllm_pkg::CMD_MOVE: begin
        nr_node = last_r;
        pr_node = item_r;
      end
      default: begin
        nr_node = anchor_r;
        pr_node = anchor_r;
      end
    endcase
  end

  // Link values as seen by the model: node 0 reads as none
  assign nx = next_z_r ? '0 : next_q_r;
  assign pr = prev_z_r ? '0 : prev_q_r;

  // The first step of a move works on the source list
  assign lst_addr = (state_r == dllm_pkg::ST_STEP_A && cmd_r == dllm_pkg::CMD_MOVE)
                    ? src_r : lid_r;
  assign cur_head = head_r[lst_addr];
  assign cur_tail = tail_r[lst_addr];

  // Whether the command does anything
  always_comb begin
    case (cmd_r)
      dllm_pkg::CMD_REMOVE, dllm_pkg::CMD_INS_TAIL, dllm_pkg::CMD_INS_HEAD,
      dllm_pkg::CMD_INS_BEFORE, dllm_pkg::CMD_INS_AFTER: go = (item_r != '0);
      dllm_pkg::CMD_MOVE:  go = (item_r != '0) && (last_r != '0);
      dllm_pkg::CMD_CLEAR: go = 1'b1;
      default:             go = 1'b0;
    endcase
  end

  // Sequencer: next state and per-step writes, in the order of the list updates
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    nw_req      = 1'b0;
    pw_req      = 1'b0;
    hw_en       = 1'b0;
    tw_en       = 1'b0;
    nw_node     = '0;
    nw_data     = '0;
    pw_node     = '0;
    pw_data     = '0;
    hw_data     = '0;
    tw_data     = '0;
    out_load    = 1'b0;
    case (state_r)
      dllm_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = dllm_pkg::ST_READ;
      end
      dllm_pkg::ST_READ: begin
        rd_en     = 1'b1;
        state_nxt = go ? dllm_pkg::ST_STEP_A : dllm_pkg::ST_DONE;
      end
      dllm_pkg::ST_STEP_A: begin
        state_nxt = dllm_pkg::ST_STEP_B;
        case (cmd_r)
          dllm_pkg::CMD_REMOVE, dllm_pkg::CMD_MOVE: begin
            // unlink: bridge predecessor and successor
            if (pr != '0) begin
              nw_req = 1'b1; nw_node = pr; nw_data = nx;
            end else begin
              hw_en = 1'b1; hw_data = nx;
            end
            if (nx != '0) begin
              pw_req = 1'b1; pw_node = nx; pw_data = pr;
            end else begin
              tw_en = 1'b1; tw_data = pr;
            end
            if (cmd_r == dllm_pkg::CMD_REMOVE) state_nxt = dllm_pkg::ST_DONE;
          end
          dllm_pkg::CMD_INS_TAIL: begin
            if (cur_tail != '0) begin
              nw_req = 1'b1; nw_node = cur_tail; nw_data = item_r;
            end else begin
              hw_en = 1'b1; hw_data = item_r;
            end
            pw_req = 1'b1; pw_node = item_r; pw_data = cur_tail;
            tw_en  = 1'b1; tw_data = item_r;
          end
          dllm_pkg::CMD_INS_HEAD: begin
            if (cur_head != '0) begin
              pw_req = 1'b1; pw_node = cur_head; pw_data = item_r;
            end else begin
              tw_en = 1'b1; tw_data = item_r;
            end
            nw_req = 1'b1; nw_node = item_r; nw_data = cur_head;
            hw_en  = 1'b1; hw_data = item_r;
          end
          dllm_pkg::CMD_INS_BEFORE: begin
            nw_req = 1'b1; nw_node = item_r; nw_data = anchor_r;
            if (anchor_r == '0) begin
              hw_en = 1'b1; hw_data = item_r;
              tw_en = 1'b1; tw_data = item_r;
              pw_req = 1'b1; pw_node = item_r; pw_data = '0;
              state_nxt = dllm_pkg::ST_DONE;
            end
          end
          dllm_pkg::CMD_INS_AFTER: begin
            pw_req = 1'b1; pw_node = item_r; pw_data = anchor_r;
            if (anchor_r == '0) begin
              hw_en = 1'b1; hw_data = item_r;
              tw_en = 1'b1; tw_data = item_r;
              nw_req = 1'b1; nw_node = item_r; nw_data = '0;
              state_nxt = dllm_pkg::ST_DONE;
            end
          end
          default: begin
            // clear
            hw_en = 1'b1;
            tw_en = 1'b1;
            state_nxt = dllm_pkg::ST_DONE;
          end
        endcase
      end
      dllm_pkg::ST_STEP_B: begin
        state_nxt = dllm_pkg::ST_STEP_C;
        case (cmd_r)
          dllm_pkg::CMD_INS_TAIL: begin
            nw_req = 1'b1; nw_node = item_r; nw_data = '0;
            state_nxt = dllm_pkg::ST_DONE;
          end
          dllm_pkg::CMD_INS_HEAD: begin
            pw_req = 1'b1; pw_node = item_r; pw_data = '0;
            state_nxt = dllm_pkg::ST_DONE;
          end
          dllm_pkg::CMD_INS_BEFORE: begin
            if (pr != '0) begin
              nw_req = 1'b1; nw_node = pr; nw_data = item_r;
            end else begin
              hw_en = 1'b1; hw_data = item_r;
            end
            pw_req = 1'b1; pw_node = item_r; pw_data = pr;
          end
          dllm_pkg::CMD_INS_AFTER: begin
            if (nx != '0) begin
              pw_req = 1'b1; pw_node = nx; pw_data = item_r;
            end else begin
              tw_en = 1'b1; tw_data = item_r;
            end
            nw_req = 1'b1; nw_node = item_r; nw_data = nx;
          end
          default: begin
            // move: append the range to the target list
            if (cur_tail != '0) begin
              nw_req = 1'b1; nw_node = cur_tail; nw_data = item_r;
            end
            pw_req = 1'b1; pw_node = item_r; pw_data = cur_tail;
            tw_en  = 1'b1; tw_data = last_r;
            if (cur_head == '0) begin
              hw_en = 1'b1; hw_data = item_r;
            end
          end
        endcase
      end
      dllm_pkg::ST_STEP_C: begin
        state_nxt = dllm_pkg::ST_DONE;
        case (cmd_r)
          dllm_pkg::CMD_INS_BEFORE: begin
            pw_req = 1'b1; pw_node = anchor_r; pw_data = item_r;
          end
          dllm_pkg::CMD_INS_AFTER: begin
            nw_req = 1'b1; nw_node = anchor_r; nw_data = item_r;
          end
          default: begin
            nw_req = 1'b1; nw_node = last_r; nw_data = '0;
          end
        endcase
      end
      dllm_pkg::ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = dllm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dllm_pkg::ST_IDLE;
    endcase
  end

  // Node 0 has no storage: its writes are dropped
  assign nw_en   = nw_req && (nw_node != '0);
  assign pw_en   = pw_req && (pw_node != '0);
  assign nw_addr = dllm_pkg::ADDR_W'(nw_node - dllm_pkg::node_t'(1));
  assign pw_addr = dllm_pkg::ADDR_W'(pw_node - dllm_pkg::node_t'(1));

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dllm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Command capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= dllm_pkg::cmd_t'(in_ch.command);
      lid_r    <= in_ch.list_id[dllm_pkg::LSEL_W-1:0];
      src_r    <= in_ch.source_list[dllm_pkg::LSEL_W-1:0];
      item_r   <= dllm_pkg::node_of(in_ch.item_node);
      anchor_r <= dllm_pkg::node_of(in_ch.anchor_node);
      last_r   <= dllm_pkg::node_of(in_ch.range_end);
    end
  end

  // Next-link RAM
  always_ff @(posedge clk) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (rd_en) begin
      next_q_r <= next_mem[dllm_pkg::ADDR_W'(nr_node - dllm_pkg::node_t'(1))];
      next_z_r <= (nr_node == '0);
    end
  end

  // Prev-link RAM
  always_ff @(posedge clk) begin
    if (pw_en) prev_mem[pw_addr] <= pw_data;
    if (rd_en) begin
      prev_q_r <= prev_mem[dllm_pkg::ADDR_W'(pr_node - dllm_pkg::node_t'(1))];
      prev_z_r <= (pr_node == '0);
    end
  end

  // List heads and tails
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < dllm_pkg::LIST_COUNT; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
      end
    end else begin
      if (hw_en) head_r[lst_addr] <= hw_data;
      if (tw_en) tail_r[lst_addr] <= tw_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      succ_out_r <= (cmd_r == dllm_pkg::CMD_REMOVE) ? nx : '0;
      head_out_r <= cur_head;
      tail_out_r <= cur_tail;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.successor_node = succ_out_r;
  assign out_ch.head_node      = head_out_r;
  assign out_ch.tail_node      = tail_out_r;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import dllm_pkg::*;

  // Code 7 is not a command; the block leaves the lists alone
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int ITEM_TARGET = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int SCRIPT_ROWS = 25;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [LIST_W-1:0] list_id;
    logic [LIST_W-1:0] source_list;
    node_t             item_node;
    node_t             anchor_node;
    node_t             range_end;
  } list_cmd_t;

  typedef struct packed {
    node_t successor;
    node_t head;
    node_t tail;
  } list_view_t;

  typedef struct packed {
    list_cmd_t  cmd;
    bit         typed;
    list_view_t want;
  } script_row_t;

  logic clk;
  logic rst_n;

  dllm_in_if  cmd_ch ();
  dllm_out_if view_ch ();

  doubly_linked_list_manager_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_ch),
    .out_ch (view_ch)
  );

  always #2 clk = ~clk;

  // Shadow of the block's state
  node_t next_of [0:NODE_COUNT];
  node_t prev_of [0:NODE_COUNT];
  bit    next_set [0:NODE_COUNT];
  bit    prev_set [0:NODE_COUNT];
  node_t first_of [LIST_COUNT];
  node_t last_of [LIST_COUNT];

  // Ownership while the lists are kept consistent
  int home_of [0:NODE_COUNT];
  int length_of [LIST_COUNT];

  list_view_t pending_views [$];
  int  mismatches = 0;
  int  items_sent = 0;
  bit  tx_eager = 1'b0;
  logic rx_hold;

  // Directed walk from reset; typed rows carry their obvious result
  script_row_t script [0:SCRIPT_ROWS-1] = '{
    '{'{CMD_CLEAR,      4'd0,  4'd0,  9'd0,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_REMOVE,     4'd3,  4'd0,  9'd0,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_UNUSED,     4'd15, 4'd15, 9'd511, 9'd511, 9'd511}, 1'b1, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_INS_TAIL,   4'd0,  4'd0,  9'd1,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd1, 9'd1}},
    '{'{CMD_INS_TAIL,   4'd0,  4'd0,  9'd256, 9'd0,   9'd0},   1'b1, '{9'd0, 9'd1, 9'd256}},
    '{'{CMD_INS_HEAD,   4'd15, 4'd0,  9'd2,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd2, 9'd2}},
    '{'{CMD_INS_HEAD,   4'd15, 4'd0,  9'd3,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd3, 9'd2}},
    '{'{CMD_INS_TAIL,   4'd1,  4'd0,  9'd257, 9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_INS_TAIL,   4'd1,  4'd0,  9'd511, 9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_INS_BEFORE, 4'd0,  4'd0,  9'd4,   9'd256, 9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_INS_AFTER,  4'd0,  4'd0,  9'd5,   9'd256, 9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_INS_BEFORE, 4'd2,  4'd0,  9'd6,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd6, 9'd6}},
    '{'{CMD_INS_AFTER,  4'd3,  4'd0,  9'd7,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd7, 9'd7}},
    '{'{CMD_INS_BEFORE, 4'd0,  4'd0,  9'd8,   9'd1,   9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_INS_AFTER,  4'd15, 4'd0,  9'd9,   9'd2,   9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_REMOVE,     4'd0,  4'd0,  9'd256, 9'd0,   9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_REMOVE,     4'd0,  4'd0,  9'd5,   9'd0,   9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_REMOVE,     4'd15, 4'd0,  9'd3,   9'd0,   9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_MOVE,       4'd3,  4'd0,  9'd1,   9'd0,   9'd4},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_MOVE,       4'd3,  4'd0,  9'd8,   9'd0,   9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_MOVE,       4'd3,  4'd0,  9'd8,   9'd0,   9'd400}, 1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_MOVE,       4'd15, 4'd15, 9'd2,   9'd0,   9'd9},   1'b0, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_REMOVE,     4'd2,  4'd0,  9'd6,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_CLEAR,      4'd3,  4'd0,  9'd0,   9'd0,   9'd0},   1'b1, '{9'd0, 9'd0, 9'd0}},
    '{'{CMD_REMOVE,     4'd15, 4'd0,  9'd257, 9'd0,   9'd0},   1'b0, '{9'd0, 9'd0, 9'd0}}
  };

  // Numbers past the pool stand for no node
  function automatic node_t clip_node(input node_t v);
    return (v > NODE_W'(NODE_COUNT)) ? '0 : v;
  endfunction

  // Node 0 keeps no links
  function automatic void set_next(input node_t n, input node_t v);
    if (n != 0) begin
      next_of[n] = v;
      next_set[n] = 1'b1;
    end
  endfunction

  function automatic void set_prev(input node_t n, input node_t v);
    if (n != 0) begin
      prev_of[n] = v;
      prev_set[n] = 1'b1;
    end
  endfunction

  // Applies one command to the shadow lists and returns what the block reports
  function automatic list_view_t advance_lists(input list_cmd_t c);
    int l;
    int s;
    node_t it, an, en, nx, pr, t, h, bp, ex;
    list_view_t v;
    l = int'(c.list_id) % LIST_COUNT;
    s = int'(c.source_list) % LIST_COUNT;
    it = clip_node(c.item_node);
    an = clip_node(c.anchor_node);
    en = clip_node(c.range_end);
    v.successor = '0;
    case (c.command)
      CMD_REMOVE: begin
        if (it != 0) begin
          nx = next_of[it];
          pr = prev_of[it];
          if (pr != 0) set_next(pr, nx); else first_of[l] = nx;
          if (nx != 0) set_prev(nx, pr); else last_of[l] = pr;
          v.successor = nx;
        end
      end
      CMD_INS_TAIL: begin
        if (it != 0) begin
          t = last_of[l];
          if (t != 0) set_next(t, it); else first_of[l] = it;
          set_next(it, '0);
          set_prev(it, t);
          last_of[l] = it;
        end
      end
      CMD_INS_HEAD: begin
        if (it != 0) begin
          h = first_of[l];
          if (h != 0) set_prev(h, it); else last_of[l] = it;
          set_next(it, h);
          set_prev(it, '0);
          first_of[l] = it;
        end
      end
      CMD_INS_BEFORE: begin
        if (it != 0) begin
          set_next(it, an);
          if (an == 0) begin
            first_of[l] = it;
            last_of[l] = it;
            set_prev(it, '0);
          end else begin
            pr = prev_of[an];
            if (pr != 0) set_next(pr, it); else first_of[l] = it;
            set_prev(it, pr);
            set_prev(an, it);
          end
        end
      end
      CMD_INS_AFTER: begin
        if (it != 0) begin
          set_prev(it, an);
          if (an == 0) begin
            first_of[l] = it;
            last_of[l] = it;
            set_next(it, '0);
          end else begin
            nx = next_of[an];
            if (nx != 0) set_prev(nx, it); else last_of[l] = it;
            set_next(it, nx);
            set_next(an, it);
          end
        end
      end
      CMD_MOVE: begin
        if (it != 0 && en != 0) begin
          // cut from the source first, then append to the target tail
          bp = prev_of[it];
          ex = next_of[en];
          if (bp != 0) set_next(bp, ex); else first_of[s] = ex;
          if (ex != 0) set_prev(ex, bp); else last_of[s] = bp;
          t = last_of[l];
          if (t != 0) set_next(t, it);
          set_prev(it, t);
          set_next(en, '0);
          last_of[l] = en;
          if (first_of[l] == 0) first_of[l] = it;
        end
      end
      CMD_CLEAR: begin
        first_of[l] = '0;
        last_of[l] = '0;
      end
      default: begin
      end
    endcase
    v.head = first_of[l];
    v.tail = last_of[l];
    return v;
  endfunction

  // True when the command reads no link that was never written
  function automatic bit links_known(input list_cmd_t c);
    node_t it, an, en;
    it = clip_node(c.item_node);
    an = clip_node(c.anchor_node);
    en = clip_node(c.range_end);
    case (c.command)
      CMD_REMOVE:     return it == 0 || (next_set[it] && prev_set[it]);
      CMD_INS_BEFORE: return it == 0 || an == 0 || prev_set[an];
      CMD_INS_AFTER:  return it == 0 || an == 0 || next_set[an];
      CMD_MOVE:       return it == 0 || en == 0 || (prev_set[it] && next_set[en]);
      default:        return 1'b1;
    endcase
  endfunction

  function automatic node_t nth_member(input int l, input int idx);
    node_t n;
    n = first_of[l];
    repeat (idx) n = next_of[n];
    return n;
  endfunction

  function automatic node_t grab_free_node();
    int r;
    int k;
    int n;
    r = $urandom_range(1, NODE_COUNT);
    for (k = 0; k < NODE_COUNT; k++) begin
      n = ((r - 1 + k) % NODE_COUNT) + 1;
      if (home_of[n] < 0) return NODE_W'(n);
    end
    return '0;
  endfunction

  function automatic node_t noisy_node();
    if ($urandom_range(0, 3) == 0) return NODE_W'($urandom_range(0, 511));
    return NODE_W'($urandom_range(0, NODE_COUNT));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at %0t: %0s got %0d want %0d", $realtime, what, got, want);
  endtask

  // Offers one command, waits for the transfer, records its expected view
  task automatic push_command(input list_cmd_t c, input bit typed, input list_view_t lit);
    int pause;
    list_view_t v;
    if (items_sent % 40 == 0) tx_eager = ($urandom_range(0, 2) == 0);
    pause = tx_eager ? 0 : $urandom_range(0, 15);
    if (pause != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= c.command;
    cmd_ch.list_id     <= c.list_id;
    cmd_ch.source_list <= c.source_list;
    cmd_ch.item_node   <= c.item_node;
    cmd_ch.anchor_node <= c.anchor_node;
    cmd_ch.range_end   <= c.range_end;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    v = advance_lists(c);
    pending_views.push_back(typed ? lit : v);
    items_sent++;
    @(negedge clk);
  endtask

  // Consistent command against the current lists; unused fields carry random bits
  task automatic draw_wellformed(input int base, input int span, output list_cmd_t c);
    int l, s, i, j, k, pick, len;
    node_t n, w, b, e;
    logic [CMD_W-1:0] op;
    l = (base + $urandom_range(0, span)) % LIST_COUNT;
    s = (base + $urandom_range(0, span)) % LIST_COUNT;
    n = grab_free_node();
    pick = $urandom_range(0, 99);
    if (pick < 20) op = CMD_REMOVE;
    else if (pick < 35) op = CMD_INS_TAIL;
    else if (pick < 48) op = CMD_INS_HEAD;
    else if (pick < 60) op = CMD_INS_BEFORE;
    else if (pick < 72) op = CMD_INS_AFTER;
    else if (pick < 96) op = CMD_MOVE;
    else op = CMD_CLEAR;
    if ((op == CMD_REMOVE && length_of[l] == 0) || (op == CMD_MOVE && length_of[s] == 0))
      op = CMD_INS_TAIL;
    if (n == 0 && (op == CMD_INS_TAIL || op == CMD_INS_HEAD ||
                   op == CMD_INS_BEFORE || op == CMD_INS_AFTER))
      op = (length_of[l] != 0) ? CMD_REMOVE : CMD_CLEAR;
    c.command     = op;
    c.list_id     = LIST_W'(l);
    c.source_list = LIST_W'($urandom);
    c.item_node   = NODE_W'($urandom);
    c.anchor_node = NODE_W'($urandom);
    c.range_end   = NODE_W'($urandom);
    len = length_of[l];
    case (op)
      CMD_REMOVE: begin
        w = nth_member(l, $urandom_range(0, len - 1));
        c.item_node = w;
        home_of[w] = -1;
        length_of[l]--;
      end
      CMD_INS_TAIL, CMD_INS_HEAD: begin
        c.item_node = n;
        home_of[n] = l;
        length_of[l]++;
      end
      CMD_INS_BEFORE, CMD_INS_AFTER: begin
        c.item_node = n;
        c.anchor_node = (len == 0) ? '0 : nth_member(l, $urandom_range(0, len - 1));
        home_of[n] = l;
        length_of[l]++;
      end
      CMD_MOVE: begin
        i = $urandom_range(0, length_of[s] - 1);
        j = $urandom_range(i, length_of[s] - 1);
        b = nth_member(s, i);
        e = nth_member(s, j);
        c.source_list = LIST_W'(s);
        c.item_node = b;
        c.range_end = e;
        w = b;
        for (k = i; k <= j; k++) begin
          home_of[w] = l;
          w = next_of[w];
        end
        length_of[s] -= j - i + 1;
        length_of[l] += j - i + 1;
      end
      default: begin
        w = first_of[l];
        for (k = 0; k < len; k++) begin
          home_of[w] = -1;
          w = next_of[w];
        end
        length_of[l] = 0;
      end
    endcase
  endtask

  // Arbitrary fields, redrawn until no unwritten link gets read, else the unused code
  task automatic draw_noise(output list_cmd_t c);
    int tries;
    for (tries = 0; tries < 32; tries++) begin
      c.command     = CMD_W'($urandom_range(0, 7));
      c.list_id     = LIST_W'($urandom);
      c.source_list = LIST_W'($urandom);
      c.item_node   = noisy_node();
      c.anchor_node = noisy_node();
      c.range_end   = noisy_node();
      if (links_known(c)) return;
    end
    c.command = CMD_UNUSED;
  endtask

  // One phase: empty every list, run consistent traffic, end with noise
  task automatic run_phase();
    int base, span, k;
    list_cmd_t c;
    base = $urandom_range(0, LIST_COUNT - 1);
    span = $urandom_range(1, LIST_COUNT - 1);
    for (k = 0; k < LIST_COUNT; k++) begin
      c.command     = CMD_CLEAR;
      c.list_id     = LIST_W'(k);
      c.source_list = LIST_W'($urandom);
      c.item_node   = NODE_W'($urandom);
      c.anchor_node = NODE_W'($urandom);
      c.range_end   = NODE_W'($urandom);
      push_command(c, 1'b0, '0);
      length_of[k] = 0;
    end
    for (k = 0; k <= NODE_COUNT; k++) home_of[k] = -1;
    repeat ($urandom_range(50, 70)) begin
      draw_wellformed(base, span, c);
      push_command(c, 1'b0, '0);
    end
    repeat ($urandom_range(4, 10)) begin
      draw_noise(c);
      push_command(c, 1'b0, '0);
    end
  endtask

  // Stimulus and end of run
  initial begin : stimulus
    int k;
    clk = 1'b0;
    rst_n = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.list_id = '0;
    cmd_ch.source_list = '0;
    cmd_ch.item_node = '0;
    cmd_ch.anchor_node = '0;
    cmd_ch.range_end = '0;
    for (k = 0; k <= NODE_COUNT; k++) begin
      next_of[k] = '0;
      prev_of[k] = '0;
      next_set[k] = 1'b0;
      prev_set[k] = 1'b0;
    end
    for (k = 0; k < LIST_COUNT; k++) begin
      first_of[k] = '0;
      last_of[k] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (k = 0; k < SCRIPT_ROWS; k++)
      push_command(script[k].cmd, script[k].typed, script[k].want);
    while (items_sent < ITEM_TARGET) run_phase();
    cmd_ch.valid <= 1'b0;

    while (pending_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: random stalls per transfer, plus the long hold-off
  initial begin : result_side
    int stall_left;
    int transfers;
    bit rx_eager;
    list_view_t want;
    view_ch.ready = 1'b0;
    stall_left = 0;
    transfers = 0;
    rx_eager = 1'b0;
    forever begin
      @(posedge clk);
      if (view_ch.valid && view_ch.ready) begin
        if (pending_views.size() == 0) begin
          report_mismatch("unexpected result, head", int'(view_ch.head_node), 0);
        end else begin
          want = pending_views.pop_front();
          if (view_ch.successor_node !== want.successor)
            report_mismatch("successor", int'(view_ch.successor_node), int'(want.successor));
          if (view_ch.head_node !== want.head)
            report_mismatch("head", int'(view_ch.head_node), int'(want.head));
          if (view_ch.tail_node !== want.tail)
            report_mismatch("tail", int'(view_ch.tail_node), int'(want.tail));
        end
        transfers++;
        if (transfers % 40 == 0) rx_eager = ($urandom_range(0, 2) == 0);
        stall_left = rx_eager ? 0 : $urandom_range(0, 15);
      end
      @(negedge clk);
      view_ch.ready <= (stall_left == 0) && !rx_hold;
      if (stall_left > 0) stall_left--;
    end
  end

  // Long receiver hold-off while commands keep coming
  initial begin : hold_off
    int held;
    rx_hold = 1'b0;
    wait (items_sent >= 250);
    @(negedge clk);
    rx_hold <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    @(negedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog
  initial begin : watchdog
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
